// File: sv/assert_macros.svh
// assertion macros shared by the top level and atcr_mdiv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every clock edge out of reset
`define CHK_IMPLY(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/atcr_pkg.sv
// shared types and constants for the arrival time capture and ranking block
`default_nettype none

package atcr_pkg;

    localparam int NUM_SENSORS_DEF = 5;
    localparam int TIME_W          = 32;
    localparam int CFG_W           = 28;
    localparam int BITCNT_W        = 5;
    localparam int IN_DATA_W       = 40;
    localparam int OUT_DATA_W      = 80;

    localparam logic [27:0]        FREQ_RESET = 28'd1000000;
    localparam logic signed [10:0] TEMP_RESET = 11'sd200;
    localparam logic [2:0]         MINV_RESET = 3'd3;
    localparam logic [2:0]         ORDER_NONE = 3'd7;
    // sound speed at 0 C in mm/s
    localparam logic [19:0]        SPEED_BASE = 20'd331500;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_HIT   = 2'd1,
        OP_EVAL  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_TIMER_FREQ = 2'd0,
        REG_AIR_TEMP   = 2'd1,
        REG_MIN_VALID  = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        STAT_VALID   = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANK_SHIFT,
        ST_RANK_SUM,
        ST_RANK_FIX,
        ST_OUT_CHECK,
        ST_OUT_MUL,
        ST_OUT_DIVINIT,
        ST_OUT_DIV,
        ST_OUT_LOAD
    } state_t;

    typedef struct packed {
        logic clear;
        logic wr_en;
        logic rot;
        logic start;
    } lane_ctl_t;

    typedef struct packed {
        logic start;
        logic mul_step;
        logic mul_bit;
        logic div_init;
        logic div_step;
    } mdiv_cmd_t;

    typedef struct packed {
        logic        any_fixed;
        logic        any_missing;
        logic        too_few;
        logic [2:0]  valid_count;
        logic [31:0] distance_um;
        logic [31:0] delay_count;
        logic [2:0]  arrival_rank;
        logic [1:0]  sensor_status;
        logic [2:0]  out_sensor;
    } result_t;

endpackage

`default_nettype wire

// File: sv/arrival_time_capture_and_ranking.sv
// top level: arrival time capture, rank correction and per-sensor delay and distance
//
//  channel   dir   handshake          payload
//  s_        in    tvalid/tready      tuser opcode, tdata sensor_index and capture_count
//  m_        out   tvalid/tready      tdata result fields, tlast on final sensor
//  cfg_      in    we (no wait)       index, wdata
//
//  evaluate ranks each sensor with one 32-bit lane turn, a sum over the sensors and a fix step;
//  then each valid sensor goes through check, multiply, divide setup, divide and load,
//  and each other one through check and load only
//  reset is synchronous and active low, no clearing pass; m_tready low only holds loads
`default_nettype none

`include "assert_macros.svh"

module arrival_time_capture_and_ranking #(
    parameter int NUM_SENSORS = atcr_pkg::NUM_SENSORS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // sensor_index [2:0], capture_count [34:3], zero fill
    input  wire logic [atcr_pkg::IN_DATA_W-1:0]       s_tdata,
    // opcode [1:0]
    input  wire logic [1:0]                           s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // out_sensor [2:0], sensor_status [4:3], arrival_rank [7:5], delay_count [39:8],
    // distance_um [71:40], valid_count [74:72], too_few [75], any_missing [76],
    // any_fixed [77], zero fill
    output logic [atcr_pkg::OUT_DATA_W-1:0]           m_tdata,
    output logic                                      m_tlast,
    input  wire logic                                 cfg_we,
    input  wire logic [1:0]                           cfg_index,
    input  wire logic [atcr_pkg::CFG_W-1:0]           cfg_wdata
);

    localparam int IW = $clog2(NUM_SENSORS);
    localparam int VW = $clog2(NUM_SENSORS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SENSORS - 1);
    localparam logic [atcr_pkg::BITCNT_W-1:0] LAST_BIT = atcr_pkg::BITCNT_W'(atcr_pkg::TIME_W - 1);

    atcr_pkg::state_t state_reg, state_next;

    logic [IW-1:0]                  cnt_reg, cnt_next;
    logic [IW-1:0]                  sum_idx_reg, sum_idx_next;
    logic [atcr_pkg::BITCNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [2:0]                     rank_reg, rank_next;
    logic [IW-1:0]                  first_reg, first_next;
    logic [VW-1:0]                  valid_cnt_reg, valid_cnt_next;
    logic                           missing_reg, missing_next;
    logic                           fixed_reg, fixed_next;
    logic [2:0]                     order_cnt_reg, order_cnt_next;

    logic [atcr_pkg::CFG_W-1:0]     freq_reg;
    logic signed [10:0]             temp_reg;
    logic [2:0]                     minv_reg;

    logic [2:0]                     order_reg [NUM_SENSORS];
    logic [IW-1:0]                  ord_idx;
    logic [2:0]                     ord_rd;
    logic                           ord_we;
    logic                           ord_clear;
    logic [2:0]                     ord_wdata;
    logic [2:0]                     fix_ord;

    logic                           m_tvalid_reg, m_tvalid_next;
    atcr_pkg::result_t              out_data_reg;
    logic                           out_last_reg;
    atcr_pkg::result_t              res;
    logic                           out_load;
    logic                           out_free;

    atcr_pkg::lane_ctl_t            lane_ctl;
    atcr_pkg::mdiv_cmd_t            mdiv_cmd;
    logic [NUM_SENSORS-1:0]         gt;
    logic                           diff_bit;
    logic [atcr_pkg::TIME_W-1:0]    delay_val;
    logic [atcr_pkg::TIME_W-1:0]    dist_val;
    atcr_pkg::status_t              status;
    logic                           idx_ok;

    atcr_lanes #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_lanes (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (lane_ctl),
        .wr_idx   (ord_idx),
        .wr_data  (s_tdata[34:3]),
        .sel_a    (cnt_reg),
        .sel_b    (first_reg),
        .gt       (gt),
        .diff_bit (diff_bit)
    );

    atcr_mdiv u_mdiv (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (mdiv_cmd),
        .timer_freq  (freq_reg),
        .air_temp    (temp_reg),
        .delay_count (delay_val),
        .distance_um (dist_val)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg <= atcr_pkg::FREQ_RESET;
            temp_reg <= atcr_pkg::TEMP_RESET;
            minv_reg <= atcr_pkg::MINV_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                atcr_pkg::REG_TIMER_FREQ: freq_reg <= cfg_wdata;
                atcr_pkg::REG_AIR_TEMP:   temp_reg <= signed'(cfg_wdata[10:0]);
                atcr_pkg::REG_MIN_VALID:  minv_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // arrival orders, one shared address for read and write
    assign ord_idx = (state_reg == atcr_pkg::ST_IDLE) ? IW'(s_tdata[2:0]) : cnt_reg;
    assign ord_rd  = order_reg[ord_idx];
    assign idx_ok  = int'(s_tdata[2:0]) < NUM_SENSORS;

    always_ff @(posedge aclk) begin
        if (!aresetn || ord_clear) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                order_reg[i] <= atcr_pkg::ORDER_NONE;
            end
        end else if (ord_we) begin
            order_reg[ord_idx] <= ord_wdata;
        end
    end

    always_comb begin
        if (ord_rd == atcr_pkg::ORDER_NONE) begin
            status = atcr_pkg::STAT_MISSING;
        end else if (int'(ord_rd) < NUM_SENSORS) begin
            status = atcr_pkg::STAT_VALID;
        end else begin
            status = atcr_pkg::STAT_RANGE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= atcr_pkg::ST_IDLE;
            order_cnt_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            order_cnt_reg <= order_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        sum_idx_reg   <= sum_idx_next;
        bit_cnt_reg   <= bit_cnt_next;
        rank_reg      <= rank_next;
        first_reg     <= first_next;
        valid_cnt_reg <= valid_cnt_next;
        missing_reg   <= missing_next;
        fixed_reg     <= fixed_next;
        if (out_load) begin
            out_data_reg <= res;
            out_last_reg <= (cnt_reg == LAST_IDX);
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sum_idx_next   = sum_idx_reg;
        bit_cnt_next   = bit_cnt_reg;
        rank_next      = rank_reg;
        first_next     = first_reg;
        valid_cnt_next = valid_cnt_reg;
        missing_next   = missing_reg;
        fixed_next     = fixed_reg;
        order_cnt_next = order_cnt_reg;
        s_tready       = 1'b0;
        lane_ctl       = '0;
        mdiv_cmd       = '0;
        ord_we         = 1'b0;
        ord_clear      = 1'b0;
        ord_wdata      = ord_rd;
        fix_ord        = ord_rd;
        out_load       = 1'b0;

        case (state_reg)
            atcr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (s_tuser)
                        atcr_pkg::OP_CLEAR: begin
                            lane_ctl.clear = 1'b1;
                            ord_clear      = 1'b1;
                            order_cnt_next = '0;
                        end
                        atcr_pkg::OP_HIT: begin
                            if (idx_ok && ord_rd == atcr_pkg::ORDER_NONE) begin
                                lane_ctl.wr_en = 1'b1;
                                ord_we         = 1'b1;
                                ord_wdata      = order_cnt_reg;
                                order_cnt_next = order_cnt_reg + 3'd1;
                            end
                        end
                        atcr_pkg::OP_EVAL: begin
                            lane_ctl.start = 1'b1;
                            cnt_next       = '0;
                            bit_cnt_next   = '0;
                            first_next     = '0;
                            valid_cnt_next = '0;
                            missing_next   = 1'b0;
                            fixed_next     = 1'b0;
                            state_next     = atcr_pkg::ST_RANK_SHIFT;
                        end
                        default: ;
                    endcase
                end
            end
            atcr_pkg::ST_RANK_SHIFT: begin
                lane_ctl.rot = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == LAST_BIT) begin
                    sum_idx_next = '0;
                    rank_next    = '0;
                    state_next   = atcr_pkg::ST_RANK_SUM;
                end
            end
            atcr_pkg::ST_RANK_SUM: begin
                rank_next    = rank_reg + 3'(gt[sum_idx_reg]);
                sum_idx_next = sum_idx_reg + 1'b1;
                if (sum_idx_reg == LAST_IDX) begin
                    state_next = atcr_pkg::ST_RANK_FIX;
                end
            end
            atcr_pkg::ST_RANK_FIX: begin
                if (ord_rd == atcr_pkg::ORDER_NONE) begin
                    missing_next = 1'b1;
                end else if (ord_rd != rank_reg) begin
                    fixed_next = 1'b1;
                    ord_we     = 1'b1;
                    ord_wdata  = rank_reg;
                    fix_ord    = rank_reg;
                end
                if (fix_ord != atcr_pkg::ORDER_NONE && int'(fix_ord) < NUM_SENSORS) begin
                    valid_cnt_next = valid_cnt_reg + 1'b1;
                    if (fix_ord == 3'd0) begin
                        first_next = cnt_reg;
                    end
                end
                if (cnt_reg == LAST_IDX) begin
                    cnt_next   = '0;
                    state_next = atcr_pkg::ST_OUT_CHECK;
                end else begin
                    cnt_next       = cnt_reg + 1'b1;
                    bit_cnt_next   = '0;
                    lane_ctl.start = 1'b1;
                    state_next     = atcr_pkg::ST_RANK_SHIFT;
                end
            end
            atcr_pkg::ST_OUT_CHECK: begin
                if (status == atcr_pkg::STAT_VALID) begin
                    lane_ctl.start = 1'b1;
                    mdiv_cmd.start = 1'b1;
                    bit_cnt_next   = '0;
                    state_next     = atcr_pkg::ST_OUT_MUL;
                end else begin
                    state_next = atcr_pkg::ST_OUT_LOAD;
                end
            end
            atcr_pkg::ST_OUT_MUL: begin
                lane_ctl.rot      = 1'b1;
                mdiv_cmd.mul_step = 1'b1;
                mdiv_cmd.mul_bit  = diff_bit;
                bit_cnt_next      = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == LAST_BIT) begin
                    state_next = atcr_pkg::ST_OUT_DIVINIT;
                end
            end
            atcr_pkg::ST_OUT_DIVINIT: begin
                mdiv_cmd.div_init = 1'b1;
                bit_cnt_next      = '0;
                state_next        = atcr_pkg::ST_OUT_DIV;
            end
            atcr_pkg::ST_OUT_DIV: begin
                mdiv_cmd.div_step = 1'b1;
                bit_cnt_next      = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == LAST_BIT) begin
                    state_next = atcr_pkg::ST_OUT_LOAD;
                end
            end
            atcr_pkg::ST_OUT_LOAD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (cnt_reg == LAST_IDX) begin
                        state_next = atcr_pkg::ST_IDLE;
                    end else begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = atcr_pkg::ST_OUT_CHECK;
                    end
                end
            end
            default: begin
                state_next = atcr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.out_sensor    = 3'(cnt_reg);
        res.sensor_status = status;
        res.arrival_rank  = ord_rd;
        res.delay_count   = (status == atcr_pkg::STAT_VALID) ? delay_val : '0;
        res.distance_um   = (status == atcr_pkg::STAT_VALID) ? dist_val : '0;
        res.valid_count   = 3'(valid_cnt_reg);
        res.too_few       = int'(valid_cnt_reg) < int'(minv_reg);
        res.any_missing   = missing_reg;
        res.any_fixed     = fixed_reg;
    end

    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_data_reg};
    assign m_tlast  = out_last_reg;

    `CHK_IMPLY(a_busy_until_last, aclk, aresetn, m_tvalid && m_tready && !m_tlast, state_reg != atcr_pkg::ST_IDLE, "result taken before the last while block idle")
    `CHK_NEXT(a_nothing_after_last, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid, "result pending after the final sensor")
    `CHK_IMPLY(a_first_has_order_zero, aclk, aresetn, state_reg == atcr_pkg::ST_OUT_CHECK && valid_cnt_reg != '0, order_reg[first_reg] == 3'd0, "reference sensor without order zero")

endmodule

`default_nettype wire

// File: sv/atcr_lanes.sv
// capture time shift lanes with bit-serial compare and subtract
`default_nettype none

module atcr_lanes #(
    parameter int NUM_SENSORS = atcr_pkg::NUM_SENSORS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire atcr_pkg::lane_ctl_t                     ctl,
    input  wire logic [$clog2(NUM_SENSORS)-1:0]          wr_idx,
    input  wire logic [atcr_pkg::TIME_W-1:0]             wr_data,
    input  wire logic [$clog2(NUM_SENSORS)-1:0]          sel_a,
    input  wire logic [$clog2(NUM_SENSORS)-1:0]          sel_b,
    output logic [NUM_SENSORS-1:0]                       gt,
    output logic                                         diff_bit
);

    logic [atcr_pkg::TIME_W-1:0] time_reg [NUM_SENSORS];
    logic [NUM_SENSORS-1:0]      gt_reg;
    logic                        borrow_reg;
    logic [NUM_SENSORS-1:0]      lane_bit;
    logic                        a_bit;
    logic                        b_bit;

    always_comb begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
            lane_bit[i] = time_reg[i][0];
        end
    end

    assign a_bit    = lane_bit[sel_a];
    assign b_bit    = lane_bit[sel_b];
    assign diff_bit = a_bit ^ b_bit ^ borrow_reg;
    assign gt       = gt_reg;

    // lsb first rotation, a full turn leaves every lane as it was
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                time_reg[i] <= '1;
            end
        end else if (ctl.wr_en) begin
            time_reg[wr_idx] <= wr_data;
        end else if (ctl.rot) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                time_reg[i] <= {time_reg[i][0], time_reg[i][atcr_pkg::TIME_W-1:1]};
            end
        end
    end

    // higher differing bits arrive later and override
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            gt_reg     <= '0;
            borrow_reg <= 1'b0;
        end else if (ctl.rot) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                gt_reg[i] <= (a_bit != lane_bit[i]) ? a_bit : gt_reg[i];
            end
            borrow_reg <= (~a_bit & b_bit) | (~(a_bit ^ b_bit) & borrow_reg);
        end
    end

endmodule

`default_nettype wire

// File: sv/atcr_mdiv.sv
// serial multiply by sound speed and restoring division by timer frequency
`default_nettype none

`include "assert_macros.svh"

module atcr_mdiv (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire atcr_pkg::mdiv_cmd_t               cmd,
    input  wire logic [atcr_pkg::CFG_W-1:0]        timer_freq,
    input  wire logic signed [10:0]                air_temp,
    output logic [atcr_pkg::TIME_W-1:0]            delay_count,
    output logic [atcr_pkg::TIME_W-1:0]            distance_um
);

    logic [19:0] temp_ext;
    logic [19:0] speed_sum;
    logic [18:0] speed_reg;
    logic [28:0] speed_k;
    logic [28:0] k_reg;
    logic [29:0] mul_sum;
    logic [28:0] acc_reg;
    logic [31:0] lo_reg;
    logic [31:0] delay_reg;
    logic [27:0] rem_reg;
    logic        sat_reg;
    logic [28:0] freq_ext;
    logic [28:0] div_trial;
    logic        div_ge;

    // speed in mm/s, then times 1000 for micrometres
    assign temp_ext  = {{9{air_temp[10]}}, air_temp};
    assign speed_sum = atcr_pkg::SPEED_BASE + (temp_ext << 6) - (temp_ext << 2) + temp_ext;
    assign speed_k   = {speed_reg, 10'b0} - {6'b0, speed_reg, 4'b0} - {7'b0, speed_reg, 3'b0};

    always_ff @(posedge aclk) begin
        speed_reg <= speed_sum[18:0];
        k_reg     <= speed_k;
    end

    assign mul_sum   = {1'b0, acc_reg} + (cmd.mul_bit ? {1'b0, k_reg} : 30'd0);
    assign freq_ext  = {1'b0, timer_freq};
    assign div_trial = {rem_reg, lo_reg[31]};
    assign div_ge    = div_trial >= freq_ext;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            acc_reg <= '0;
        end else if (cmd.mul_step) begin
            acc_reg   <= mul_sum[29:1];
            lo_reg    <= {mul_sum[0], lo_reg[31:1]};
            delay_reg <= {cmd.mul_bit, delay_reg[31:1]};
        end else if (cmd.div_init) begin
            sat_reg <= (timer_freq == '0) || (acc_reg >= freq_ext);
            rem_reg <= acc_reg[27:0];
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? 28'(div_trial - freq_ext) : div_trial[27:0];
            lo_reg  <= {lo_reg[30:0], div_ge};
        end
    end

    assign delay_count = delay_reg;
    assign distance_um = sat_reg ? '1 : lo_reg;

    `CHK_IMPLY(a_rem_below_divisor, aclk, aresetn, cmd.div_step && !sat_reg, rem_reg < timer_freq, "partial remainder not below divisor")

endmodule

`default_nettype wire
